@@ rtl/lbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfs_pkg
// Shared operation and status codes, controller states and the command and
// status bundles between the controller and the datapath of the linked block file store.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfs_pkg;

  // Operation codes carried by op_i
  typedef enum logic [2:0] {
    OP_OPEN_WR = 3'd0,
    OP_OPEN_RD = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4,
    OP_REWIND  = 3'd5,
    OP_REMOVE  = 3'd6,
    OP_QUERY   = 3'd7
  } op_e;

  // Result status codes carried by status_o
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ALREADY_OPEN = 3'd1,
    ST_NO_SLOT      = 3'd2,
    ST_NO_BLOCK     = 3'd3,
    ST_NOT_OPEN     = 3'd4,
    ST_EOF          = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_LINK,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch transaction, read slot record
    logic eval;    // read link table
    logic link;    // form word address, read word store
    logic commit;  // update state, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/lbfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbfs_ctrl
// Sequencer: steps one transaction through record read, link read,
// word access and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  lbfs_pkg::dp_status_t     dp_status_i,
  output lbfs_pkg::cmd_t           cmd_o,
  output logic                     in_stall_o
);

  lbfs_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbfs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lbfs_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = lbfs_pkg::S_EVAL;
        end
      end
      lbfs_pkg::S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = lbfs_pkg::S_LINK;
      end
      lbfs_pkg::S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = lbfs_pkg::S_DONE;
      end
      lbfs_pkg::S_DONE: begin
        // hold until the result register is free
        if (dp_status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lbfs_pkg::S_IDLE;
        end
      end
      default: state_d = lbfs_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/lbfs_dp.sv @@
// ----------------------------------------------------------------------------
// lbfs_dp
// Datapath: slot flags, slot record memory, block link memory, word store,
// free list head, open-file registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfs_dp #(
  parameter int NUM_SLOTS   = 16,
  parameter int NUM_BLOCKS  = 32,
  parameter int BLOCK_WORDS = 1023
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  lbfs_pkg::cmd_t         cmd_i,
  output lbfs_pkg::dp_status_t   dp_status_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [3:0]        slot_i,
  input  wire logic [7:0]        file_kind_i,
  input  wire logic [31:0]       word_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [31:0]            word_out_o,
  output logic [3:0]             slot_out_o,
  output logic                   slot_used_o,
  output logic [7:0]             slot_kind_o,
  output logic [14:0]            slot_size_o,
  output logic [4:0]             files_in_use_o
);

  localparam int SLW    = $clog2(NUM_SLOTS);
  localparam int CNTW   = $clog2(NUM_SLOTS + 1);
  localparam int BLKW   = $clog2(NUM_BLOCKS + 1);   // holds the null code
  localparam int LIW    = $clog2(NUM_BLOCKS);
  localparam int IDXW   = $clog2(BLOCK_WORDS + 1);
  localparam int WDEPTH = NUM_BLOCKS * BLOCK_WORDS;
  localparam int SIZEW  = $clog2(WDEPTH + 1);
  localparam int ADDRW  = $clog2(WDEPTH);

  localparam logic [BLKW-1:0] NULL_BLK = BLKW'(NUM_BLOCKS);
  localparam logic [BLKW-1:0] LAST_BLK = BLKW'(NUM_BLOCKS - 1);
  localparam logic [IDXW-1:0] FULL_IDX = IDXW'(BLOCK_WORDS);

  typedef struct packed {
    logic [7:0]       kind;
    logic [BLKW-1:0]  first;
    logic [BLKW-1:0]  last;
    logic [SIZEW-1:0] size;
    logic [BLKW-1:0]  cur_blk;
    logic [IDXW-1:0]  cur_idx;
    logic [SIZEW-1:0] rpos;
  } rec_t;

  // Memories
  rec_t            rec_mem  [NUM_SLOTS];
  logic [BLKW-1:0] link_mem [NUM_BLOCKS];
  logic [31:0]     word_mem [WDEPTH];

  // Control state
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic                 open_q, open_d;
  logic                 for_wr_q, for_wr_d;
  logic [SLW-1:0]       open_slot_q, open_slot_d;
  logic [BLKW-1:0]      fh_q, fh_d;     // free list head
  logic [BLKW-1:0]      hw_q, hw_d;     // blocks below this have written links
  logic                 out_valid_q;

  // Transaction latch
  lbfs_pkg::op_e        op_q;
  logic [3:0]           slot_q;
  logic [7:0]           kind_q;
  logic [31:0]          win_q;
  logic [SLW-1:0]       free_slot, free_slot_q;
  logic                 any_free, any_free_q;
  logic [SLW-1:0]       rec_addr, rec_addr_q;

  // Memory read data and addresses
  rec_t                 rec_q;
  logic [BLKW-1:0]      link_q, link_raddr, link_raddr_q, link_val;
  logic [31:0]          rd_word_q;
  logic [ADDRW-1:0]     word_addr, word_addr_q;
  logic                 full;
  logic [BLKW-1:0]      blk_sel;

  // Commit signals
  rec_t                 rec_wd;
  logic                 rec_we;
  logic                 link_we;
  logic [BLKW-1:0]      link_wa, link_wd;
  logic                 word_we;
  logic                 slot_ok, slot_used;
  logic [SLW-1:0]       slot_idx;
  lbfs_pkg::status_e    st;
  logic [31:0]          wout;
  logic [3:0]           sout;
  logic                 sused;
  logic [7:0]           skind;
  logic [14:0]          ssize;

  // Result register
  lbfs_pkg::status_e    st_q;
  logic [31:0]          wout_q;
  logic [3:0]           sout_q;
  logic                 sused_q;
  logic [7:0]           skind_q;
  logic [14:0]          ssize_q;

  // First unused slot
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = SLW'(i);
        any_free  = 1'b1;
      end
    end
  end

  // Record address for the incoming transaction
  always_comb begin
    case (lbfs_pkg::op_e'(op_i))
      lbfs_pkg::OP_OPEN_WR: rec_addr = free_slot;
      lbfs_pkg::OP_OPEN_RD, lbfs_pkg::OP_REMOVE, lbfs_pkg::OP_QUERY:
        rec_addr = SLW'(slot_i);
      default: rec_addr = open_slot_q;
    endcase
  end

  // Transaction latch (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q        <= lbfs_pkg::op_e'(op_i);
      slot_q      <= slot_i;
      kind_q      <= file_kind_i;
      win_q       <= word_in_i;
      free_slot_q <= free_slot;
      any_free_q  <= any_free;
      rec_addr_q  <= rec_addr;
    end
  end

  // Slot record memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rec_q <= rec_mem[rec_addr];
    end
    if (rec_we) begin
      rec_mem[rec_addr_q] <= rec_wd;
    end
  end

  // Link memory: a read follows the cursor for reads, the free head otherwise
  assign link_raddr = (op_q == lbfs_pkg::OP_READ) ? rec_q.cur_blk : fh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      link_raddr_q <= link_raddr;
      if (link_raddr < NULL_BLK) begin
        link_q <= link_mem[link_raddr[LIW-1:0]];
      end
    end
    if (link_we) begin
      link_mem[link_wa[LIW-1:0]] <= link_wd;
    end
  end

  // Entries at or above the high-water mark still hold their reset chain
  always_comb begin
    if (link_raddr_q >= hw_q) begin
      link_val = (link_raddr_q == LAST_BLK) ? NULL_BLK : link_raddr_q + 1'b1;
    end else begin
      link_val = link_q;
    end
  end

  // Word address: next block when the cursor block is full
  assign full = rec_q.cur_idx >= FULL_IDX;

  always_comb begin
    if (full) begin
      blk_sel = (op_q == lbfs_pkg::OP_READ) ? link_val : fh_q;
    end else begin
      blk_sel = rec_q.cur_blk;
    end
    word_addr = ADDRW'(blk_sel) * ADDRW'(BLOCK_WORDS)
              + (full ? '0 : ADDRW'(rec_q.cur_idx));
  end

  // Word store
  always_ff @(posedge clk_i) begin
    if (cmd_i.link) begin
      word_addr_q <= word_addr;
      rd_word_q   <= word_mem[word_addr];
    end
    if (word_we) begin
      word_mem[word_addr_q] <= win_q;
    end
  end

  // Operation decode and state update
  assign slot_idx  = SLW'(slot_q);
  assign slot_ok   = {28'd0, slot_q} < NUM_SLOTS;
  assign slot_used = slot_ok && used_q[slot_idx];

  always_comb begin
    used_d      = used_q;
    cnt_d       = cnt_q;
    open_d      = open_q;
    for_wr_d    = for_wr_q;
    open_slot_d = open_slot_q;
    fh_d        = fh_q;
    hw_d        = hw_q;
    rec_wd      = rec_q;
    rec_we      = 1'b0;
    link_we     = 1'b0;
    link_wa     = rec_q.last;
    link_wd     = fh_q;
    word_we     = 1'b0;
    st          = lbfs_pkg::ST_OK;
    wout        = '0;
    sout        = '0;
    sused       = 1'b0;
    skind       = '0;
    ssize       = '0;

    case (op_q)
      lbfs_pkg::OP_OPEN_WR: begin
        if (open_q) begin
          st = lbfs_pkg::ST_ALREADY_OPEN;
        end else if (!any_free_q) begin
          st = lbfs_pkg::ST_NO_SLOT;
        end else if (fh_q == NULL_BLK) begin
          st = lbfs_pkg::ST_NO_BLOCK;
        end else begin
          used_d[free_slot_q] = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          rec_we         = 1'b1;
          rec_wd.kind    = kind_q;
          rec_wd.first   = fh_q;
          rec_wd.last    = fh_q;
          rec_wd.cur_blk = fh_q;
          rec_wd.cur_idx = '0;
          rec_wd.size    = '0;
          rec_wd.rpos    = '0;
          fh_d           = link_val;
          if (fh_q >= hw_q) hw_d = fh_q + 1'b1;
          open_d         = 1'b1;
          for_wr_d       = 1'b1;
          open_slot_d    = free_slot_q;
          sout           = 4'(free_slot_q);
        end
      end
      lbfs_pkg::OP_OPEN_RD: begin
        if (open_q) begin
          st = lbfs_pkg::ST_ALREADY_OPEN;
        end else if (!slot_used) begin
          st = lbfs_pkg::ST_NOT_OPEN;
        end else begin
          open_d      = 1'b1;
          for_wr_d    = 1'b0;
          open_slot_d = slot_idx;
        end
      end
      lbfs_pkg::OP_CLOSE: begin
        open_d   = 1'b0;
        for_wr_d = 1'b0;
      end
      lbfs_pkg::OP_WRITE: begin
        if (!open_q || !for_wr_q) begin
          st = lbfs_pkg::ST_NOT_OPEN;
        end else if (full && fh_q == NULL_BLK) begin
          st = lbfs_pkg::ST_NO_BLOCK;
        end else begin
          if (full) begin
            // chain a fresh block after the last one
            link_we        = 1'b1;
            link_wa        = rec_q.last;
            link_wd        = fh_q;
            fh_d           = link_val;
            if (fh_q >= hw_q) hw_d = fh_q + 1'b1;
            rec_wd.last    = fh_q;
            rec_wd.cur_blk = fh_q;
            rec_wd.cur_idx = IDXW'(1);
          end else begin
            rec_wd.cur_idx = rec_q.cur_idx + 1'b1;
          end
          word_we     = 1'b1;
          rec_we      = 1'b1;
          rec_wd.size = rec_q.size + 1'b1;
          rec_wd.rpos = rec_q.rpos + 1'b1;
        end
      end
      lbfs_pkg::OP_READ: begin
        if (!open_q) begin
          st = lbfs_pkg::ST_NOT_OPEN;
        end else if (rec_q.rpos >= rec_q.size || rec_q.cur_blk >= NULL_BLK) begin
          st = lbfs_pkg::ST_EOF;
        end else if (full && link_val >= NULL_BLK) begin
          st = lbfs_pkg::ST_EOF;
        end else begin
          if (full) begin
            rec_wd.cur_blk = link_val;
            rec_wd.cur_idx = IDXW'(1);
          end else begin
            rec_wd.cur_idx = rec_q.cur_idx + 1'b1;
          end
          rec_we      = 1'b1;
          rec_wd.rpos = rec_q.rpos + 1'b1;
          wout        = rd_word_q;
        end
      end
      lbfs_pkg::OP_REWIND: begin
        if (!open_q || for_wr_q) begin
          st = lbfs_pkg::ST_NOT_OPEN;
        end else begin
          rec_we         = 1'b1;
          rec_wd.cur_blk = rec_q.first;
          rec_wd.cur_idx = '0;
          rec_wd.rpos    = '0;
        end
      end
      lbfs_pkg::OP_REMOVE: begin
        if (!slot_used) begin
          st = lbfs_pkg::ST_NOT_OPEN;
        end else if (open_q && open_slot_q == slot_idx) begin
          st = lbfs_pkg::ST_ALREADY_OPEN;
        end else begin
          // splice the whole chain onto the free list
          link_we          = 1'b1;
          link_wa          = rec_q.last;
          link_wd          = fh_q;
          fh_d             = rec_q.first;
          used_d[slot_idx] = 1'b0;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        sout = slot_q;
        if (!slot_ok) begin
          st = lbfs_pkg::ST_NOT_OPEN;
        end else if (slot_used) begin
          sused = 1'b1;
          skind = rec_q.kind;
          ssize = 15'(rec_q.size);
        end
      end
    endcase

    if (!cmd_i.commit) begin
      rec_we  = 1'b0;
      link_we = 1'b0;
      word_we = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      cnt_q       <= '0;
      open_q      <= 1'b0;
      for_wr_q    <= 1'b0;
      open_slot_q <= '0;
      fh_q        <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        used_q      <= used_d;
        cnt_q       <= cnt_d;
        open_q      <= open_d;
        for_wr_q    <= for_wr_d;
        open_slot_q <= open_slot_d;
        fh_q        <= fh_d;
        hw_q        <= hw_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      st_q    <= st;
      wout_q  <= wout;
      sout_q  <= sout;
      sused_q <= sused;
      skind_q <= skind;
      ssize_q <= ssize;
    end
  end

  assign dp_status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = st_q;
  assign word_out_o     = wout_q;
  assign slot_out_o     = sout_q;
  assign slot_used_o    = sused_q;
  assign slot_kind_o    = skind_q;
  assign slot_size_o    = ssize_q;
  assign files_in_use_o = 5'(cnt_q);

endmodule

`default_nettype wire

@@ rtl/linked_block_file_store.sv @@
// ----------------------------------------------------------------------------
// linked_block_file_store
// File store of fixed word blocks chained per file, with a free block list.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   op, slot, file_kind, word_in
//   out      output     out_valid_o / out_stall_i status, word_out, slot_out,
//                                                 slot_used, slot_kind,
//                                                 slot_size, files_in_use
//
// Each transaction steps through accept with slot record read, link read,
// word store access and commit; the word store read follows the link lookup.
// Reset needs no clearing pass; the free list is tracked with a high-water
// mark. A stalled result holds in the output register and the next
// transaction is still accepted; its commit waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_block_file_store #(
  parameter int NUM_SLOTS   = 16,
  parameter int NUM_BLOCKS  = 32,
  parameter int BLOCK_WORDS = 1023
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [7:0]  file_kind_i,
  input  wire logic [31:0] word_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      word_out_o,
  output logic [3:0]       slot_out_o,
  output logic             slot_used_o,
  output logic [7:0]       slot_kind_o,
  output logic [14:0]      slot_size_o,
  output logic [4:0]       files_in_use_o
);

  lbfs_pkg::cmd_t       cmd;
  lbfs_pkg::dp_status_t dp_status;

  lbfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  lbfs_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .dp_status_o    (dp_status),
    .op_i           (op_i),
    .slot_i         (slot_i),
    .file_kind_i    (file_kind_i),
    .word_in_i      (word_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .word_out_o     (word_out_o),
    .slot_out_o     (slot_out_o),
    .slot_used_o    (slot_used_o),
    .slot_kind_o    (slot_kind_o),
    .slot_size_o    (slot_size_o),
    .files_in_use_o (files_in_use_o)
  );

endmodule

`default_nettype wire
